// ===== design/slle_pkg.sv =====
package slle_pkg;

  // One input item: operation, 1-based position, element data.
  typedef struct packed {
    logic        cmd;
    logic [7:0]  position;
    logic [31:0] value;
  } in_item_t;

  // One result item: completion code and list length after the operation.
  typedef struct packed {
    logic [1:0] status;
    logic [7:0] list_length;
  } out_item_t;

  localparam logic CMD_INSERT = 1'b0;
  localparam logic CMD_DELETE = 1'b1;

  localparam logic [1:0] STAT_DONE  = 2'd0;
  localparam logic [1:0] STAT_RANGE = 2'd1;
  localparam logic [1:0] STAT_FULL  = 2'd2;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_CHECK,
    ST_TAKE,
    ST_WALK,
    ST_INS_LINK,
    ST_INS_HOOK,
    ST_DEL_J,
    ST_DEL_UNLINK,
    ST_DEL_FREE,
    ST_DONE
  } state_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic latch;
    logic clr_wr;
    logic chk;
    logic take_rd;
    logic take_fin;
    logic walk_start;
    logic walk_rd;
    logic ins_link;
    logic ins_hook;
    logic del_j;
    logic del_unlink;
    logic del_free;
  } ctl_cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic clr_last;
    logic ok;
    logic is_del;
    logic steps_zero;
  } dp_stat_t;

endpackage

// ===== design/slle_dp.sv =====
module slle_dp #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  slle_pkg::ctl_cmd_t   cmd,
  input  slle_pkg::in_item_t   in_item,
  output slle_pkg::dp_stat_t   stat,
  output slle_pkg::out_item_t  out_item
);
  import slle_pkg::*;

  localparam int AW = $clog2(DEPTH);
  localparam int CW = (AW > 8 ? AW : 8) + 1;
  localparam logic [AW-1:0] HEAD_SLOT = AW'(DEPTH - 1);
  localparam logic [AW-1:0] LAST_FREE = AW'(DEPTH - 2);

  logic [AW-1:0]         link_mem [DEPTH];
  logic [DATA_WIDTH-1:0] data_mem [DEPTH];

  in_item_t      item_r;
  logic [AW-1:0] clr_r;
  logic [AW-1:0] free_head_r;
  logic [AW-1:0] count_r;
  logic [AW-1:0] j_r;
  logic [AW-1:0] k_r;
  logic [AW-1:0] rd_data_r;
  logic [7:0]    steps_r;
  logic          fwd_r;
  logic [1:0]    status_r;

  logic [AW-1:0] k_cur;
  logic [CW-1:0] pos_ext;
  logic [CW-1:0] cnt_ext;
  logic          pos_bad;
  logic          no_free;
  logic [1:0]    chk_status;

  logic          rd_en;
  logic [AW-1:0] rd_addr;
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [AW-1:0] wr_data;

  // During the walk the next address comes straight from the last read.
  assign k_cur   = fwd_r ? rd_data_r : k_r;
  assign pos_ext = CW'(item_r.position);
  assign cnt_ext = CW'(count_r);
  assign no_free = (free_head_r == '0);

  always_comb begin
    if (item_r.cmd == CMD_INSERT) begin
      pos_bad = (item_r.position == 8'd0) || (pos_ext > cnt_ext + CW'(1));
    end else begin
      pos_bad = (item_r.position == 8'd0) || (pos_ext > cnt_ext);
    end
    if (pos_bad) begin
      chk_status = STAT_RANGE;
    end else if (item_r.cmd == CMD_INSERT && no_free) begin
      chk_status = STAT_FULL;
    end else begin
      chk_status = STAT_DONE;
    end
  end

  assign stat.clr_last   = (clr_r == HEAD_SLOT);
  assign stat.ok         = (chk_status == STAT_DONE);
  assign stat.is_del     = (item_r.cmd == CMD_DELETE);
  assign stat.steps_zero = (steps_r == 8'd0);

  assign out_item.status      = status_r;
  assign out_item.list_length = cnt_ext[7:0];

  always_comb begin
    rd_en   = cmd.take_rd | cmd.walk_rd | cmd.del_j;
    rd_addr = k_cur;
    if (cmd.take_rd) begin
      rd_addr = free_head_r;
    end else if (cmd.del_j) begin
      rd_addr = rd_data_r;
    end
  end

  always_comb begin
    wr_en   = 1'b1;
    wr_addr = j_r;
    wr_data = rd_data_r;
    if (cmd.clr_wr) begin
      // Initial free chain: each slot points to the next, the last two end it.
      wr_addr = clr_r;
      wr_data = (clr_r >= LAST_FREE) ? '0 : clr_r + AW'(1);
    end else if (cmd.ins_link) begin
      wr_addr = j_r;
      wr_data = rd_data_r;
    end else if (cmd.ins_hook) begin
      wr_addr = k_r;
      wr_data = j_r;
    end else if (cmd.del_unlink) begin
      wr_addr = k_r;
      wr_data = rd_data_r;
    end else if (cmd.del_free) begin
      wr_addr = j_r;
      wr_data = free_head_r;
    end else begin
      wr_en = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      link_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data_r <= link_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.take_fin) begin
      data_mem[j_r] <= DATA_WIDTH'(item_r.value);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      item_r <= in_item;
    end
    if (cmd.chk) begin
      status_r <= chk_status;
    end
    if (cmd.take_rd) begin
      j_r <= free_head_r;
    end else if (cmd.del_j) begin
      j_r <= rd_data_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_r       <= '0;
      free_head_r <= AW'(1);
      count_r     <= '0;
      k_r         <= HEAD_SLOT;
      steps_r     <= 8'd0;
      fwd_r       <= 1'b0;
    end else begin
      if (cmd.clr_wr) begin
        clr_r <= clr_r + AW'(1);
      end
      if (cmd.take_fin) begin
        free_head_r <= rd_data_r;
      end else if (cmd.del_free) begin
        free_head_r <= j_r;
      end
      if (cmd.ins_hook) begin
        count_r <= count_r + AW'(1);
      end else if (cmd.del_free) begin
        count_r <= count_r - AW'(1);
      end
      if (cmd.walk_start) begin
        k_r     <= HEAD_SLOT;
        steps_r <= item_r.position - 8'd1;
        fwd_r   <= 1'b0;
      end else if (cmd.walk_rd) begin
        k_r   <= k_cur;
        fwd_r <= 1'b1;
        if (steps_r != 8'd0) begin
          steps_r <= steps_r - 8'd1;
        end
      end
    end
  end

endmodule

// ===== design/slle_ctrl.sv =====
module slle_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                start,
  input  slle_pkg::dp_stat_t  stat,
  output slle_pkg::ctl_cmd_t  cmd,
  output logic                busy,
  output logic                out_valid
);
  import slle_pkg::*;

  state_t state_r;
  state_t state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      ST_CLEAR: begin
        if (stat.clr_last) state_nxt = ST_IDLE;
      end
      ST_IDLE: begin
        if (start) state_nxt = ST_CHECK;
      end
      ST_CHECK: begin
        if (!stat.ok) begin
          state_nxt = ST_DONE;
        end else if (stat.is_del) begin
          state_nxt = ST_WALK;
        end else begin
          state_nxt = ST_TAKE;
        end
      end
      ST_TAKE: state_nxt = ST_WALK;
      ST_WALK: begin
        if (stat.steps_zero) state_nxt = stat.is_del ? ST_DEL_J : ST_INS_LINK;
      end
      ST_INS_LINK:   state_nxt = ST_INS_HOOK;
      ST_INS_HOOK:   state_nxt = ST_DONE;
      ST_DEL_J:      state_nxt = ST_DEL_UNLINK;
      ST_DEL_UNLINK: state_nxt = ST_DEL_FREE;
      ST_DEL_FREE:   state_nxt = ST_DONE;
      ST_DONE:       state_nxt = ST_IDLE;
      default:       state_nxt = ST_CLEAR;
    endcase
  end

  always_comb begin
    cmd       = '0;
    busy      = 1'b1;
    out_valid = 1'b0;
    unique case (state_r)
      ST_CLEAR: cmd.clr_wr = 1'b1;
      ST_IDLE: begin
        busy      = 1'b0;
        cmd.latch = start;
      end
      ST_CHECK: begin
        cmd.chk        = 1'b1;
        cmd.take_rd    = stat.ok & ~stat.is_del;
        cmd.walk_start = stat.ok & stat.is_del;
      end
      ST_TAKE: begin
        cmd.take_fin   = 1'b1;
        cmd.walk_start = 1'b1;
      end
      ST_WALK:       cmd.walk_rd    = 1'b1;
      ST_INS_LINK:   cmd.ins_link   = 1'b1;
      ST_INS_HOOK:   cmd.ins_hook   = 1'b1;
      ST_DEL_J:      cmd.del_j      = 1'b1;
      ST_DEL_UNLINK: cmd.del_unlink = 1'b1;
      ST_DEL_FREE:   cmd.del_free   = 1'b1;
      ST_DONE:       out_valid      = 1'b1;
      default:       cmd            = '0;
    endcase
  end

endmodule

// ===== design/static_linked_list_engine_top.sv =====
// The walk down the link memory reads one link per cycle through its single read port, at
// most 255 links; a new item is taken only after the previous item's result strobe.
// Reset: synchronous, active low; a clearing pass then rebuilds the free chain with busy
// high. Each result shows for one cycle; the receiver cannot stall.
module static_linked_list_engine_top #(
  parameter int DEPTH      = 256,
  parameter int DATA_WIDTH = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 start,
  output logic                 busy,
  input  slle_pkg::in_item_t   in_item,
  output logic                 out_valid,
  output slle_pkg::out_item_t  out_item
);
  import slle_pkg::*;

  // Commands from the sequencer, status back from the datapath.
  ctl_cmd_t ctl_cmd;
  dp_stat_t dp_stat;

  // Sequencer: clearing pass, range check, free-slot take, link walk, relink, report.
  slle_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .stat      (dp_stat),
    .cmd       (ctl_cmd),
    .busy      (busy),
    .out_valid (out_valid)
  );

  // Datapath: link memory with registered read, data memory, free head, element count,
  // and the walk cursor that chains each read result into the next address.
  slle_dp #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_dp (
    .clk      (clk),
    .rst_n    (rst_n),
    .cmd      (ctl_cmd),
    .in_item  (in_item),
    .stat     (dp_stat),
    .out_item (out_item)
  );

endmodule

// ===== design/slle_checker.sv =====
module slle_checker (
  input logic                clk,
  input logic                rst_n,
  input logic                start,
  input logic                busy,
  input logic                out_valid,
  input slle_pkg::out_item_t out_item
);
  import slle_pkg::*;

  // An accepted item keeps the block busy until its result.
  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    start && !busy |=> busy)
    else $error("accepted item did not raise busy");

  // A result strobe lasts one cycle and leaves the block idle.
  a_strobe_once: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !out_valid && !busy)
    else $error("result strobe not followed by idle");

  // No result appears while the block is ready for a new item.
  a_strobe_busy: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> busy)
    else $error("result strobe while idle");

  // Only the three defined completion codes are reported.
  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_item.status == STAT_DONE || out_item.status == STAT_RANGE ||
                   out_item.status == STAT_FULL))
    else $error("undefined status code");

endmodule

bind static_linked_list_engine_top slle_checker u_slle_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_item  (out_item)
);

// ===== tb/tb.sv =====
`timescale 1ns / 1ps

module tb;
  import slle_pkg::*;

  localparam int         SLOTS        = 256;
  localparam logic [7:0] LIST_HEAD    = 8'd255;  // last slot heads the list
  localparam logic [7:0] FREE_HEAD    = 8'd0;    // slot 0 heads the free chain
  localparam int         MAX_ELEMS    = 254;
  localparam int         STALL_LIMIT  = 4000;    // well above the longest walk for one item
  localparam int         DRAIN_CYCLES = 300;
  localparam int         RAND_ITEMS   = 1830;

  typedef struct {
    in_item_t  item;
    bit        typed;  // expected result written into the table
    out_item_t want;
  } dir_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      start;
  logic      busy;
  in_item_t  in_item;
  logic      out_valid;
  out_item_t out_item;

  // Mirror of the link memory and the element count.
  logic [7:0]  next_slot [SLOTS];
  int unsigned elem_count;

  // Results still owed by the block, oldest first.
  out_item_t   owed_results [$];
  dir_row_t    dir_rows [$];
  int unsigned errors = 0;
  int unsigned stall_cycles = 0;

  static_linked_list_engine_top dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (start),
    .busy      (busy),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  task automatic report_mismatch(input string msg);
    errors++;
    $display("[%0t] mismatch: %s", $time, msg);
  endtask

  // Rebuild the free chain 0 -> 1 -> ... -> 254 and leave the list empty.
  function automatic void list_clear();
    for (int i = 0; i < SLOTS; i++) next_slot[i] = 8'(i + 1);
    next_slot[SLOTS-2] = 8'd0;
    next_slot[SLOTS-1] = 8'd0;
    elem_count = 0;
  endfunction

  // Follow pos-1 links from the list head to reach the slot before pos.
  function automatic logic [7:0] walk_to_prev(input logic [7:0] pos);
    logic [7:0] slot;
    slot = LIST_HEAD;
    for (int n = 1; n < pos; n++) slot = next_slot[slot];
    return slot;
  endfunction

  // Apply one operation to the mirror and return status and new length.
  function automatic out_item_t list_apply(input in_item_t it);
    out_item_t  res;
    logic [7:0] taken;
    logic [7:0] prev;
    res.status = STAT_DONE;
    if (it.cmd == CMD_INSERT) begin
      if (it.position == 0 || it.position > elem_count + 1) begin
        res.status = STAT_RANGE;
      end else if (next_slot[FREE_HEAD] == 8'd0) begin
        res.status = STAT_FULL;
      end else begin
        taken                = next_slot[FREE_HEAD];
        next_slot[FREE_HEAD] = next_slot[taken];
        prev                 = walk_to_prev(it.position);
        next_slot[taken]     = next_slot[prev];
        next_slot[prev]      = taken;
        elem_count++;
      end
    end else begin
      if (it.position == 0 || it.position > elem_count) begin
        res.status = STAT_RANGE;
      end else begin
        prev                 = walk_to_prev(it.position);
        taken                = next_slot[prev];
        next_slot[prev]      = next_slot[taken];
        next_slot[taken]     = next_slot[FREE_HEAD];
        next_slot[FREE_HEAD] = taken;
        elem_count--;
      end
    end
    res.list_length = elem_count[7:0];
    return res;
  endfunction

  task automatic add_row(input logic cmd, input int pos, input logic [31:0] val,
                         input bit typed, input logic [1:0] st, input int len);
    dir_row_t row;
    row.item.cmd         = cmd;
    row.item.position    = 8'(pos);
    row.item.value       = val;
    row.typed            = typed;
    row.want.status      = st;
    row.want.list_length = 8'(len);
    dir_rows.push_back(row);
  endtask

  // Build a random item: mostly in-range positions biased toward filling or
  // draining the list, with a tenth of pure noise.
  function automatic in_item_t make_item(input bit filling);
    in_item_t it;
    case ($urandom_range(3))
      0:       it.value = 32'h0000_0000;
      1:       it.value = 32'hFFFF_FFFF;
      default: it.value = $urandom;
    endcase
    if ($urandom_range(99) < 10) begin
      it.cmd      = 1'($urandom_range(1));
      it.position = 8'($urandom_range(255));
    end else begin
      it.cmd = ($urandom_range(99) < (filling ? 80 : 20)) ? CMD_INSERT : CMD_DELETE;
      if (it.cmd == CMD_INSERT)
        it.position = 8'($urandom_range(elem_count + 1, 1));
      else if (elem_count == 0)
        it.position = 8'($urandom_range(255));
      else
        it.position = 8'($urandom_range(elem_count, 1));
    end
    return it;
  endfunction

  // Present one item, idling first at the given rate, and hold it until the
  // block takes it; then predict and queue its result. Leave start high so a
  // back-to-back item needs no second assignment in the same step.
  task automatic send_item(input in_item_t it, input bit typed, input out_item_t want,
                           input int idle_pct);
    out_item_t pred;
    while (idle_pct > 0 && $urandom_range(99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk);
    end
    start   <= 1'b1;
    in_item <= it;
    @(posedge clk);
    while (busy) @(posedge clk);
    pred = list_apply(it);
    owed_results.push_back(typed ? want : pred);
  endtask

  // Drop start and hold off until every owed result has come back.
  task automatic wait_drained();
    start <= 1'b0;
    while (owed_results.size() != 0) @(posedge clk);
  endtask

  // Compare every strobed result with the oldest owed one, field by field.
  always @(posedge clk) begin : check_results
    out_item_t want;
    if (rst_n === 1'b1 && out_valid === 1'b1) begin
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("unexpected result status=%0d length=%0d",
                                  out_item.status, out_item.list_length));
      end else begin
        want = owed_results.pop_front();
        if (out_item.status !== want.status)
          report_mismatch($sformatf("status %0d, want %0d", out_item.status, want.status));
        if (out_item.list_length !== want.list_length)
          report_mismatch($sformatf("list_length %0d, want %0d",
                                    out_item.list_length, want.list_length));
      end
    end
  end

  // Count cycles with no item taken and no result strobed; stop a hung run.
  always @(posedge clk) begin
    if (rst_n !== 1'b1 || (start === 1'b1 && busy === 1'b0) || out_valid === 1'b1) begin
      stall_cycles <= 0;
    end else if (stall_cycles == STALL_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin : stimulus
    int        idle_pcts [3];
    bit        filling;
    out_item_t none;
    idle_pcts = '{0, 64, 11};
    filling   = 1'b1;
    none      = '0;
    rst_n   <= 1'b0;
    start   <= 1'b0;
    in_item <= '0;
    list_clear();

    // Directed table: empty-list rejects, both ends, the middle, bounds.
    add_row(CMD_DELETE,   1, 32'h0000_0000, 1, STAT_RANGE, 0);  // delete on empty list
    add_row(CMD_INSERT,   0, 32'h0000_0000, 1, STAT_RANGE, 0);  // position zero
    add_row(CMD_INSERT,   2, 32'h1234_5678, 1, STAT_RANGE, 0);  // past length+1
    add_row(CMD_INSERT,   1, 32'h0000_0000, 1, STAT_DONE,  1);
    add_row(CMD_INSERT,   1, 32'hFFFF_FFFF, 1, STAT_DONE,  2);  // new front
    add_row(CMD_INSERT,   3, 32'h8000_0000, 1, STAT_DONE,  3);  // append at tail
    add_row(CMD_INSERT,   5, 32'h0000_0001, 1, STAT_RANGE, 3);
    add_row(CMD_INSERT, 255, 32'h7FFF_FFFF, 1, STAT_RANGE, 3);  // top position
    add_row(CMD_DELETE,   0, 32'h0000_0000, 1, STAT_RANGE, 3);
    add_row(CMD_DELETE,   4, 32'h0000_0000, 1, STAT_RANGE, 3);  // past length
    add_row(CMD_DELETE, 255, 32'hFFFF_FFFF, 1, STAT_RANGE, 3);
    add_row(CMD_INSERT,   2, 32'hA5A5_A5A5, 0, STAT_DONE,  0);  // middle insert
    add_row(CMD_DELETE,   2, 32'h0000_0000, 0, STAT_DONE,  0);  // middle delete
    add_row(CMD_DELETE,   3, 32'h0000_0000, 0, STAT_DONE,  0);  // tail delete
    add_row(CMD_DELETE,   1, 32'h0000_0000, 0, STAT_DONE,  0);  // front delete
    add_row(CMD_INSERT,   2, 32'h5A5A_5A5A, 0, STAT_DONE,  0);
    add_row(CMD_DELETE,   1, 32'hFFFF_FFFF, 0, STAT_DONE,  0);  // value ignored
    add_row(CMD_DELETE,   1, 32'h0000_0000, 1, STAT_DONE,  0);  // back to empty
    add_row(CMD_DELETE,   1, 32'h0000_0000, 1, STAT_RANGE, 0);
    add_row(CMD_INSERT,   1, 32'hFFFF_FFFF, 1, STAT_DONE,  1);
    add_row(CMD_DELETE,   1, 32'h0000_0000, 1, STAT_DONE,  0);

    // Hold reset low, then release it for good.
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    // Walk the directed table back to back; the first item waits out the
    // clearing pass behind busy.
    foreach (dir_rows[i]) send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want, 0);
    wait_drained();

    // Random phases at different sender idle rates; between phases, pause
    // until nothing is owed. Fill toward a full table, linger there so full
    // inserts get hit, then drain back to empty, and repeat.
    foreach (idle_pcts[p]) begin
      repeat (RAND_ITEMS / 3) begin
        if (elem_count >= MAX_ELEMS && $urandom_range(3) == 0)
          filling = 1'b0;
        else if (elem_count == 0)
          filling = 1'b1;
        send_item(make_item(filling), 1'b0, none, idle_pcts[p]);
      end
      wait_drained();
    end

    // Let any stray strobe show up before the verdict.
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (errors == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule

// ===== sim.f =====
design/slle_pkg.sv
design/slle_dp.sv
design/slle_ctrl.sv
design/static_linked_list_engine_top.sv
design/slle_checker.sv
tb/tb.sv
